@@ rtl/core/rsf_pkg.sv @@
// rsf_pkg: shared constants, command record and literal text tables for the
// stream flattener. No dependencies.
`default_nettype none
package rsf_pkg;

   localparam int NUMBER_BITS = 32;
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BULK  = 8'h24;
   localparam logic [7:0] CH_ARRAY = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_NUM   = 2'd1;
   localparam logic [1:0] ERR_SHORT = 2'd2;
   localparam logic [1:0] ERR_ELEM  = 2'd3;

   localparam logic [47:0] TXT_NULL  = "(null)";
   localparam logic [55:0] TXT_EMPTY = "(empty)";
   localparam logic [31:0] TXT_WORD  = "none";

   typedef enum logic [1:0] {
      LIT_NONE,
      LIT_NULL,
      LIT_EMPTY,
      LIT_WORD
   } lit_type;

   typedef struct packed {
      lit_type    lit;
      logic       b0_vld;
      logic [7:0] b0;
      logic       b1_vld;
      logic [7:0] b1;
      logic       space;
      logic       fail;
      logic [1:0] err;
      logic       last;
   } cmd_type;

   function automatic logic [2:0] lit_len(lit_type kind);
      logic [2:0] len;
      case (kind)
         LIT_NULL:  len = 3'd6;
         LIT_EMPTY: len = 3'd7;
         LIT_WORD:  len = 3'd4;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lit_char(lit_type kind, logic [2:0] idx);
      logic [7:0] ch;
      case (kind)
         LIT_NULL:  ch = TXT_NULL[8*(5 - int'(idx)) +: 8];
         LIT_EMPTY: ch = TXT_EMPTY[8*(6 - int'(idx)) +: 8];
         LIT_WORD:  ch = TXT_WORD[8*(3 - int'(idx)) +: 8];
         default:   ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/rsf_front.sv @@
// rsf_front: byte parser; classifies each accepted byte and issues one command
// record per byte that yields text or an end. Depends on rsf_pkg.
`default_nettype none
module rsf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_message,
   output rsf_pkg::cmd_type      cmd,
   output logic                  cmd_push
);

   localparam int NB    = rsf_pkg::NUMBER_BITS;
   localparam int ACC_W = NB + 4;

   typedef enum logic [3:0] {
      PH_TYPE, PH_LINE, PH_INTL, PH_BLEN, PH_ALEN,
      PH_ELEM, PH_BODY, PH_SKIP, PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      DG_NONE, DG_SIGN, DG_DIGITS, DG_STOP
   } digits_type;

   phase_type        phase_ff, phase_in;
   logic [NB-1:0]    content_ff, content_in;
   logic [NB-1:0]    elems_ff, elems_in;
   logic [NB-1:0]    accum_ff, accum_in;
   logic             neg_ff, neg_in;
   digits_type       digits_ff, digits_in;
   logic             held_cr_ff, held_cr_in;
   logic             in_array_ff, in_array_in;
   logic [1:0]       skip_ff, skip_in;

   logic             is_digit;
   logic             is_space;
   logic             num_phase;
   logic             line_end;
   logic             cnt_neg;
   logic [ACC_W-1:0] prod;
   logic [ACC_W-1:0] limit;

   assign is_digit  = (data_byte >= rsf_pkg::CH_ZERO) && (data_byte <= rsf_pkg::CH_NINE);
   assign is_space  = (data_byte == rsf_pkg::CH_SP) ||
                      ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
   assign num_phase = (phase_ff == PH_BLEN) || (phase_ff == PH_ALEN);
   assign line_end  = held_cr_ff && (data_byte == rsf_pkg::CH_LF);
   assign cnt_neg   = neg_ff && (accum_ff != '0);
   assign prod      = (ACC_W'(accum_ff) << 3) + (ACC_W'(accum_ff) << 1) +
                      ACC_W'(data_byte[3:0]);
   assign limit     = (ACC_W'(1) << (NB - 1)) - (neg_ff ? ACC_W'(0) : ACC_W'(1));

   always_comb begin
      phase_in    = phase_ff;
      content_in  = content_ff;
      elems_in    = elems_ff;
      accum_in    = accum_ff;
      neg_in      = neg_ff;
      digits_in   = digits_ff;
      held_cr_in  = held_cr_ff;
      in_array_in = in_array_ff;
      skip_in     = skip_ff;
      cmd         = '0;
      cmd.lit     = rsf_pkg::LIT_NONE;

      unique case (phase_ff)
         PH_TYPE: begin
            in_array_in = 1'b0;
            if (data_byte == rsf_pkg::CH_PLUS || data_byte == rsf_pkg::CH_MINUS ||
                data_byte == rsf_pkg::CH_COLON) begin
               held_cr_in = 1'b0;
               phase_in   = PH_LINE;
            end else if (data_byte == rsf_pkg::CH_BULK || data_byte == rsf_pkg::CH_ARRAY) begin
               accum_in   = '0;
               neg_in     = 1'b0;
               digits_in  = DG_NONE;
               held_cr_in = 1'b0;
               phase_in   = (data_byte == rsf_pkg::CH_BULK) ? PH_BLEN : PH_ALEN;
            end else begin
               cmd.lit  = rsf_pkg::LIT_WORD;
               phase_in = PH_DONE;
            end
         end
         PH_ELEM: begin
            if (data_byte == rsf_pkg::CH_BULK) begin
               accum_in   = '0;
               neg_in     = 1'b0;
               digits_in  = DG_NONE;
               held_cr_in = 1'b0;
               phase_in   = PH_BLEN;
            end else if (data_byte == rsf_pkg::CH_COLON) begin
               held_cr_in = 1'b0;
               phase_in   = PH_INTL;
            end else if (data_byte == rsf_pkg::CH_PLUS || data_byte == rsf_pkg::CH_MINUS) begin
               held_cr_in = 1'b0;
               phase_in   = PH_LINE;
            end else begin
               cmd.fail = 1'b1;
               cmd.err  = rsf_pkg::ERR_ELEM;
               cmd.last = 1'b1;
               phase_in = PH_FAIL;
            end
         end
         PH_LINE, PH_INTL, PH_BLEN, PH_ALEN: begin
            if (held_cr_ff) begin
               held_cr_in = 1'b0;
               if (line_end) begin
                  if (num_phase) begin
                     if (digits_ff == DG_NONE || digits_ff == DG_SIGN) begin
                        cmd.fail = 1'b1;
                        cmd.err  = rsf_pkg::ERR_NUM;
                        cmd.last = 1'b1;
                        phase_in = PH_FAIL;
                     end else if (phase_ff == PH_BLEN) begin
                        if (cnt_neg && accum_ff == NB'(1)) begin
                           cmd.lit = rsf_pkg::LIT_NULL;
                           if (in_array_ff) begin
                              cmd.space = 1'b1;
                              if (elems_in != '0) elems_in = elems_in - NB'(1);
                              phase_in = (elems_in != '0) ? PH_ELEM : PH_DONE;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end else if (cnt_neg) begin
                           cmd.fail = 1'b1;
                           cmd.err  = rsf_pkg::ERR_NUM;
                           cmd.last = 1'b1;
                           phase_in = PH_FAIL;
                        end else if (accum_ff == '0) begin
                           cmd.lit = rsf_pkg::LIT_EMPTY;
                           if (in_array_ff) begin
                              skip_in   = 2'd2;
                              cmd.space = 1'b1;
                              if (elems_in != '0) elems_in = elems_in - NB'(1);
                              phase_in = (elems_in != '0) ? PH_SKIP : PH_DONE;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end else begin
                           content_in = accum_ff;
                           phase_in   = PH_BODY;
                        end
                     end else begin
                        if (cnt_neg && accum_ff == NB'(1)) begin
                           cmd.lit  = rsf_pkg::LIT_NULL;
                           phase_in = PH_DONE;
                        end else if (cnt_neg || accum_ff == '0) begin
                           phase_in = PH_DONE;
                        end else begin
                           elems_in    = accum_ff;
                           in_array_in = 1'b1;
                           phase_in    = PH_ELEM;
                        end
                     end
                  end else if (in_array_ff) begin
                     cmd.space = 1'b1;
                     if (elems_in != '0) elems_in = elems_in - NB'(1);
                     phase_in = (elems_in != '0) ? PH_ELEM : PH_DONE;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end else if (!num_phase) begin
                  cmd.b0_vld = 1'b1;
                  cmd.b0     = rsf_pkg::CH_CR;
               end else if (digits_ff == DG_DIGITS) begin
                  digits_in = DG_STOP;
               end else if (digits_ff == DG_SIGN) begin
                  cmd.fail = 1'b1;
                  cmd.err  = rsf_pkg::ERR_NUM;
                  cmd.last = 1'b1;
                  phase_in = PH_FAIL;
               end
            end
            if (!line_end && phase_in != PH_FAIL) begin
               if (data_byte == rsf_pkg::CH_CR) begin
                  held_cr_in = 1'b1;
               end else if (!num_phase) begin
                  if (cmd.b0_vld) begin
                     cmd.b1_vld = 1'b1;
                     cmd.b1     = data_byte;
                  end else begin
                     cmd.b0_vld = 1'b1;
                     cmd.b0     = data_byte;
                  end
               end else if (digits_in != DG_STOP) begin
                  if (is_digit) begin
                     if (prod > limit) begin
                        cmd.fail = 1'b1;
                        cmd.err  = rsf_pkg::ERR_NUM;
                        cmd.last = 1'b1;
                        phase_in = PH_FAIL;
                     end else begin
                        accum_in  = prod[NB-1:0];
                        digits_in = DG_DIGITS;
                     end
                  end else if (digits_in == DG_DIGITS) begin
                     digits_in = DG_STOP;
                  end else if (digits_in == DG_NONE && is_space) begin
                     digits_in = DG_NONE;
                  end else if (digits_in == DG_NONE &&
                               (data_byte == rsf_pkg::CH_PLUS ||
                                data_byte == rsf_pkg::CH_MINUS)) begin
                     neg_in    = (data_byte == rsf_pkg::CH_MINUS);
                     digits_in = DG_SIGN;
                  end else begin
                     cmd.fail = 1'b1;
                     cmd.err  = rsf_pkg::ERR_NUM;
                     cmd.last = 1'b1;
                     phase_in = PH_FAIL;
                  end
               end
            end
         end
         PH_BODY: begin
            cmd.b0_vld = 1'b1;
            cmd.b0     = data_byte;
            if (content_in != '0) content_in = content_in - NB'(1);
            if (content_in == '0) begin
               if (in_array_ff) begin
                  skip_in   = 2'd2;
                  cmd.space = 1'b1;
                  if (elems_in != '0) elems_in = elems_in - NB'(1);
                  phase_in = (elems_in != '0) ? PH_SKIP : PH_DONE;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_SKIP: begin
            if (skip_in != 2'd0) skip_in = skip_in - 2'd1;
            if (skip_in == 2'd0) phase_in = PH_ELEM;
         end
         default: begin
         end
      endcase

      if (end_of_message) begin
         unique case (phase_in)
            PH_LINE, PH_BODY: begin
               if (phase_in == PH_LINE && held_cr_in) begin
                  if (cmd.b0_vld) begin
                     cmd.b1_vld = 1'b1;
                     cmd.b1     = rsf_pkg::CH_CR;
                  end else begin
                     cmd.b0_vld = 1'b1;
                     cmd.b0     = rsf_pkg::CH_CR;
                  end
               end
               if (in_array_in) begin
                  cmd.space = 1'b1;
                  if (elems_in != '0) elems_in = elems_in - NB'(1);
                  if (elems_in != '0) begin
                     cmd.fail = 1'b1;
                     cmd.err  = rsf_pkg::ERR_SHORT;
                     phase_in = PH_FAIL;
                  end
               end
            end
            PH_INTL, PH_BLEN, PH_ALEN: begin
               cmd.fail = 1'b1;
               cmd.err  = rsf_pkg::ERR_NUM;
               phase_in = PH_FAIL;
            end
            PH_SKIP, PH_ELEM: begin
               cmd.fail = 1'b1;
               cmd.err  = rsf_pkg::ERR_SHORT;
               phase_in = PH_FAIL;
            end
            default: begin
            end
         endcase
         if (phase_ff != PH_FAIL) cmd.last = 1'b1;
         phase_in    = PH_TYPE;
         content_in  = '0;
         elems_in    = '0;
         accum_in    = '0;
         neg_in      = 1'b0;
         digits_in   = DG_NONE;
         held_cr_in  = 1'b0;
         in_array_in = 1'b0;
         skip_in     = 2'd0;
      end
   end

   assign cmd_push = take && ((cmd.lit != rsf_pkg::LIT_NONE) || cmd.b0_vld || cmd.b1_vld ||
                              cmd.space || cmd.fail || cmd.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         content_ff  <= '0;
         elems_ff    <= '0;
         accum_ff    <= '0;
         neg_ff      <= 1'b0;
         digits_ff   <= DG_NONE;
         held_cr_ff  <= 1'b0;
         in_array_ff <= 1'b0;
         skip_ff     <= 2'd0;
      end else if (take) begin
         phase_ff    <= phase_in;
         content_ff  <= content_in;
         elems_ff    <= elems_in;
         accum_ff    <= accum_in;
         neg_ff      <= neg_in;
         digits_ff   <= digits_in;
         held_cr_ff  <= held_cr_in;
         in_array_ff <= in_array_in;
         skip_ff     <= skip_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rsf_cmd_fifo.sv @@
// rsf_cmd_fifo: short command queue between the parser and the expander.
// Depends on rsf_pkg.
`default_nettype none
module rsf_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  rsf_pkg::cmd_type      wr_cmd,
   output logic                  full,
   input  wire logic             rd_en,
   output rsf_pkg::cmd_type      rd_cmd,
   output logic                  empty
);

   localparam int PW = rsf_pkg::CMD_PTR_W;

   rsf_pkg::cmd_type mem_ff [rsf_pkg::CMD_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW:0]      count_ff;

   assign full   = (count_ff == (PW+1)'(rsf_pkg::CMD_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         if (wr_en && !rd_en) count_ff <= count_ff + (PW+1)'(1);
         else if (rd_en && !wr_en) count_ff <= count_ff - (PW+1)'(1);
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rsf_back.sv @@
// rsf_back: expands command records into result items, one per cycle unless the
// output is held unpopped, into a single output register. Depends on rsf_pkg.
`default_nettype none
module rsf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  rsf_pkg::cmd_type      head,
   input  wire logic             head_empty,
   output logic                  head_pop,
   output logic                  empty,
   input  wire logic             pop,
   output logic                  has_byte,
   output logic [7:0]            out_byte,
   output logic                  out_last,
   output logic [1:0]            error_code
);

   typedef struct packed {
      logic       litp;
      logic [2:0] idx;
      logic       b0p;
      logic       b1p;
      logic       spp;
      logic       tailp;
   } pend_type;

   rsf_pkg::cmd_type cur_ff;
   pend_type         pend_ff, pend_in;
   logic             busy_ff;
   rsf_pkg::cmd_type view_cmd;
   pend_type         view;
   logic             fire;
   logic             more;
   logic             rsp_vld_ff;
   logic             has_in;
   logic [7:0]       byte_in;
   logic             last_in;
   logic [1:0]       err_in;

   always_comb begin
      view_cmd = busy_ff ? cur_ff : head;
      if (busy_ff) begin
         view = pend_ff;
      end else begin
         view.litp  = (head.lit != rsf_pkg::LIT_NONE);
         view.idx   = 3'd0;
         view.b0p   = head.b0_vld;
         view.b1p   = head.b1_vld;
         view.spp   = head.space;
         view.tailp = head.fail || (head.last && (head.lit == rsf_pkg::LIT_NONE) &&
                      !head.b0_vld && !head.b1_vld && !head.space);
      end
      pend_in = view;
      has_in  = 1'b1;
      byte_in = 8'h00;
      err_in  = rsf_pkg::ERR_OK;
      if (view.litp) begin
         byte_in      = rsf_pkg::lit_char(view_cmd.lit, view.idx);
         pend_in.idx  = view.idx + 3'd1;
         pend_in.litp = (view.idx + 3'd1) < rsf_pkg::lit_len(view_cmd.lit);
      end else if (view.b0p) begin
         byte_in     = view_cmd.b0;
         pend_in.b0p = 1'b0;
      end else if (view.b1p) begin
         byte_in     = view_cmd.b1;
         pend_in.b1p = 1'b0;
      end else if (view.spp) begin
         byte_in     = rsf_pkg::CH_SP;
         pend_in.spp = 1'b0;
      end else begin
         has_in        = 1'b0;
         err_in        = view_cmd.fail ? view_cmd.err : rsf_pkg::ERR_OK;
         pend_in.tailp = 1'b0;
      end
      more    = pend_in.litp || pend_in.b0p || pend_in.b1p || pend_in.spp || pend_in.tailp;
      last_in = view_cmd.last && !more;
      fire    = (busy_ff || !head_empty) && (!rsp_vld_ff || pop);
   end

   assign head_pop = fire && !busy_ff;
   assign empty    = !rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (fire) begin
            busy_ff    <= more;
            rsp_vld_ff <= 1'b1;
         end else if (pop) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) cur_ff <= head;
      if (fire) begin
         pend_ff    <= pend_in;
         has_byte   <= has_in;
         out_byte   <= byte_in;
         out_last   <= last_in;
         error_code <= err_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/resp_stream_flattener_unit.sv @@
// resp_stream_flattener_unit: top level; parser front, command queue and
// text expander. Depends on rsf_pkg, rsf_front, rsf_cmd_fifo, rsf_back.
//
//   channel   direction  handshake        payload
//   req_      in         push / full      data_byte, end_of_message
//   rsp_      out        empty / pop      has_byte, out_byte, out_last, error_code
//
// The front takes one byte per cycle while full is low and issues at most one
// command per byte. The back emits one result item per cycle unless its output
// is held unpopped; a literal such as "(empty)" goes out item by item, and the
// four-entry command queue fills meanwhile, raising full. Results pass through
// the queue and the output register. Reset is synchronous and empties both.
`default_nettype none
module resp_stream_flattener_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   output logic            empty,
   input  wire logic       pop,
   output logic            rsp_has_byte,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output logic [1:0]      rsp_error_code
);

   rsf_pkg::cmd_type fr_cmd;
   rsf_pkg::cmd_type q_head;
   logic             fr_push;
   logic             q_empty;
   logic             q_pop;
   logic             take;

   assign take = push && !full;

   rsf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .cmd            (fr_cmd),
      .cmd_push       (fr_push)
   );

   rsf_cmd_fifo u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (fr_push),
      .wr_cmd (fr_cmd),
      .full   (full),
      .rd_en  (q_pop),
      .rd_cmd (q_head),
      .empty  (q_empty)
   );

   rsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_empty (q_empty),
      .head_pop   (q_pop),
      .empty      (empty),
      .pop        (pop),
      .has_byte   (rsp_has_byte),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_out_last),
      .error_code (rsp_error_code)
   );

endmodule
`default_nettype wire

@@ rtl/core/rsf_checker.sv @@
// rsf_checker: port-level assertions for the flattener, bound to the top level.
// Depends on rsf_pkg and resp_stream_flattener_unit.
`default_nettype none
module rsf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic       rsp_has_byte,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last,
   input wire logic [1:0] rsp_error_code
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_out_last)))
      else $error("stalled result changed");

   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error_code != rsf_pkg::ERR_OK) |-> (rsp_out_last && !rsp_has_byte))
      else $error("error item not a final marker");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_has_byte) |-> (rsp_out_last && rsp_out_byte == 8'h00))
      else $error("bare marker not final or carries a byte");

endmodule

bind resp_stream_flattener_unit rsf_checker u_rsf_checker (
   .clock          (clock),
   .reset          (reset),
   .empty          (empty),
   .pop            (pop),
   .rsp_has_byte   (rsp_has_byte),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_last   (rsp_out_last),
   .rsp_error_code (rsp_error_code)
);
`default_nettype wire

@@ tb/sv/resp_stream_flattener_unit_chk.sv @@
// resp_stream_flattener_unit_chk: watches both queue channels of the flattener,
// predicts the flattened text items and compares them. Depends on rsf_pkg.
`default_nettype none
module resp_stream_flattener_unit_chk (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic       full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   input  wire logic       empty,
   input  wire logic       pop,
   input  wire logic       rsp_has_byte,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_out_last,
   input  wire logic [1:0] rsp_error_code,
   output int              fail_count,
   output int              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ITEMS = 10;

   typedef enum logic [3:0] {
      P_TYPE, P_LINE, P_INTL, P_BLEN, P_ALEN, P_ELEM, P_BODY, P_SKIP, P_DONE, P_FAIL
   } phase_type;

   typedef enum logic [1:0] {D_NONE, D_SIGN, D_DIGITS, D_STOP} digit_type;

   typedef struct {
      logic       has;
      logic [7:0] b;
      logic       last;
      logic [1:0] err;
   } text_item_type;

   text_item_type text_q[$];
   phase_type     phase;
   digit_type     dstate;
   logic [31:0]   body_left, elems_left, accum;
   logic          neg, held_cr, in_arr;
   logic [1:0]    skip_left;
   int            n_items;

   assign pending = text_q.size();

   task put(input logic has, input logic [7:0] b, input logic last, input logic [1:0] err);
      text_item_type t;
      if (n_items < MAX_ITEMS) begin
         t.has = has; t.b = b; t.last = last; t.err = err;
         text_q.push_back(t);
         n_items++;
      end
   endtask

   task put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(1'b1, s[i], 1'b0, rsf_pkg::ERR_OK);
   endtask

   task fail(input logic [1:0] code);
      put(1'b0, 8'h00, 1'b1, code);
      phase = P_FAIL;
   endtask

   task clear_state();
      phase = P_TYPE; body_left = 0; elems_left = 0; accum = 0; neg = 0;
      dstate = D_NONE; held_cr = 0; in_arr = 0; skip_left = 0;
   endtask

   task num_start();
      accum = 0; neg = 0; dstate = D_NONE; held_cr = 0;
   endtask

   task automatic num_char(input logic [7:0] c);
      logic [63:0] lim, v;
      if (dstate == D_STOP) return;
      if (c >= rsf_pkg::CH_ZERO && c <= rsf_pkg::CH_NINE) begin
         lim = (64'd1 << (rsf_pkg::NUMBER_BITS - 1)) - (neg ? 64'd0 : 64'd1);
         v = {32'd0, accum} * 64'd10 + 64'(c - rsf_pkg::CH_ZERO);
         if (v > lim) begin
            fail(rsf_pkg::ERR_NUM);
            return;
         end
         accum = v[31:0]; dstate = D_DIGITS;
         return;
      end
      if (dstate == D_DIGITS) begin
         dstate = D_STOP;
         return;
      end
      if (dstate == D_NONE) begin
         if (c == rsf_pkg::CH_SP || (c >= 8'h09 && c <= 8'h0D)) return;
         if (c == rsf_pkg::CH_PLUS || c == rsf_pkg::CH_MINUS) begin
            neg = (c == rsf_pkg::CH_MINUS); dstate = D_SIGN;
            return;
         end
      end
      fail(rsf_pkg::ERR_NUM);
   endtask

   task elem_done(input phase_type nxt);
      put(1'b1, rsf_pkg::CH_SP, 1'b0, rsf_pkg::ERR_OK);
      if (elems_left != 0) elems_left--;
      phase = (elems_left != 0) ? nxt : P_DONE;
   endtask

   task automatic count_done();
      logic n;
      if (dstate != D_DIGITS && dstate != D_STOP) begin
         fail(rsf_pkg::ERR_NUM);
         return;
      end
      n = neg && accum != 0;
      if (phase == P_BLEN) begin
         if (n && accum == 1) begin
            put_text("(null)");
            if (in_arr) elem_done(P_ELEM); else phase = P_DONE;
         end else if (n) begin
            fail(rsf_pkg::ERR_NUM);
         end else if (accum == 0) begin
            put_text("(empty)");
            if (in_arr) begin
               skip_left = 2; elem_done(P_SKIP);
            end else phase = P_DONE;
         end else begin
            body_left = accum; phase = P_BODY;
         end
      end else begin
         if (n && accum == 1) begin
            put_text("(null)"); phase = P_DONE;
         end else if (n || accum == 0) phase = P_DONE;
         else begin
            elems_left = accum; in_arr = 1; phase = P_ELEM;
         end
      end
   endtask

   task line_char(input logic [7:0] c);
      if (phase == P_LINE || phase == P_INTL) put(1'b1, c, 1'b0, rsf_pkg::ERR_OK);
      else num_char(c);
   endtask

   task line_end();
      if (phase == P_BLEN || phase == P_ALEN) count_done();
      else if (in_arr) elem_done(P_ELEM);
      else phase = P_DONE;
   endtask

   task line_byte(input logic [7:0] c);
      if (held_cr) begin
         held_cr = 0;
         if (c == rsf_pkg::CH_LF) begin
            line_end();
            return;
         end
         line_char(rsf_pkg::CH_CR);
         if (phase == P_FAIL) return;
      end
      if (c == rsf_pkg::CH_CR) held_cr = 1; else line_char(c);
   endtask

   task close_message();
      case (phase)
         P_LINE, P_BODY: begin
            if (phase == P_LINE && held_cr) put(1'b1, rsf_pkg::CH_CR, 1'b0, rsf_pkg::ERR_OK);
            if (in_arr) begin
               elem_done(P_ELEM);
               if (phase != P_DONE) fail(rsf_pkg::ERR_SHORT);
            end
         end
         P_INTL, P_BLEN, P_ALEN: fail(rsf_pkg::ERR_NUM);
         P_SKIP, P_ELEM: fail(rsf_pkg::ERR_SHORT);
         default: ;
      endcase
      if (phase != P_FAIL) begin
         if (n_items == 0) put(1'b0, 8'h00, 1'b1, rsf_pkg::ERR_OK);
         else text_q[text_q.size() - 1].last = 1'b1;
      end
   endtask

   task flatten_byte(input logic [7:0] c, input logic eom);
      n_items = 0;
      case (phase)
         P_TYPE: begin
            in_arr = 0;
            if (c == rsf_pkg::CH_PLUS || c == rsf_pkg::CH_MINUS ||
                c == rsf_pkg::CH_COLON) begin
               held_cr = 0; phase = P_LINE;
            end else if (c == rsf_pkg::CH_BULK) begin
               num_start(); phase = P_BLEN;
            end else if (c == rsf_pkg::CH_ARRAY) begin
               num_start(); phase = P_ALEN;
            end else begin
               put_text("none"); phase = P_DONE;
            end
         end
         P_ELEM: begin
            if (c == rsf_pkg::CH_BULK) begin
               num_start(); phase = P_BLEN;
            end else if (c == rsf_pkg::CH_COLON) begin
               held_cr = 0; phase = P_INTL;
            end else if (c == rsf_pkg::CH_PLUS || c == rsf_pkg::CH_MINUS) begin
               held_cr = 0; phase = P_LINE;
            end else fail(rsf_pkg::ERR_ELEM);
         end
         P_LINE, P_INTL, P_BLEN, P_ALEN: line_byte(c);
         P_BODY: begin
            put(1'b1, c, 1'b0, rsf_pkg::ERR_OK);
            if (body_left != 0) body_left--;
            if (body_left == 0) begin
               if (in_arr) begin
                  skip_left = 2; elem_done(P_SKIP);
               end else phase = P_DONE;
            end
         end
         P_SKIP: begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) phase = P_ELEM;
         end
         default: ;
      endcase
      if (eom) begin
         close_message();
         clear_state();
      end
   endtask

   initial begin
      fail_count = 0;
      clear_state();
   end

   always @(posedge clock) begin
      text_item_type t;
      if (reset) begin
         text_q.delete();
         clear_state();
      end else begin
         if (pop && !empty) begin
            if (text_q.size() == 0) begin
               $display("%0t: unexpected transaction has=%0b byte=%h last=%0b err=%0d", $time,
                        rsp_has_byte, rsp_out_byte, rsp_out_last, rsp_error_code);
               fail_count++;
            end else begin
               t = text_q.pop_front();
               if (rsp_has_byte !== t.has || rsp_out_byte !== t.b ||
                   rsp_out_last !== t.last || rsp_error_code !== t.err) begin
                  $display({"%0t: mismatch expected has=%0b byte=%h last=%0b err=%0d,",
                            " actual has=%0b byte=%h last=%0b err=%0d"},
                           $time, t.has, t.b, t.last, t.err, rsp_has_byte, rsp_out_byte,
                           rsp_out_last, rsp_error_code);
                  fail_count++;
               end
            end
         end
         if (push && !full) flatten_byte(req_data_byte, req_end_of_message);
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/resp_stream_flattener_unit_tb.sv @@
// resp_stream_flattener_unit_tb: drives RESP messages into the flattener with
// varied idling and back-pressure. Depends on rsf_pkg and resp_stream_flattener_unit_chk.
`default_nettype none
module resp_stream_flattener_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 0;
   logic       reset = 1;
   logic       push = 0;
   logic [7:0] req_data_byte = 0;
   logic       req_end_of_message = 0;
   logic       pop = 0;
   logic       full, empty, rsp_has_byte, rsp_out_last;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;
   int         fail_count, pending;
   int         send_idle = 0, recv_idle = 0, sent = 0;
   bit         hold_req = 0;
   logic [7:0] msg_q[$];

   resp_stream_flattener_unit i_dut (.*);
   resp_stream_flattener_unit_chk i_chk (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("resp_stream_flattener_unit_tb NOT OK");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      forever begin
         if (hold_req) begin
            pop <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle);
            @(posedge clock);
         end
      end
   end

   task add_str(input string s);
      for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
   endtask

   task add_crlf();
      add_str("\r\n");
   endtask

   task add_count(input int v);
      case ($urandom_range(15))
         0: add_str($sformatf(" %0d", v));
         1: add_str($sformatf("+%0d", v));
         2: add_str($sformatf("%0dz", v));
         3: add_str("x");
         4: add_str("");
         5: add_str("99999999999");
         6: add_str("-2147483648");
         7: add_str("2147483647");
         8: add_str($sformatf("%0d\r", v));
         default: add_str($sformatf("%0d", v));
      endcase
      add_crlf();
   endtask

   task add_text(input int maxlen);
      int n;
      n = $urandom_range(maxlen);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(7) == 0) msg_q.push_back(rsf_pkg::CH_CR);
         else msg_q.push_back(8'($urandom_range(7) == 0 ? $urandom_range(255)
                                                       : $urandom_range(32, 126)));
      end
   endtask

   task add_bulk();
      int len;
      len = $urandom_range(5) == 0 ? -1 - $urandom_range(2) : $urandom_range(6);
      msg_q.push_back(rsf_pkg::CH_BULK);
      add_count(len);
      for (int i = 0; i < len; i++) msg_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) add_str("ab"); else add_crlf();
   endtask

   task add_element();
      case ($urandom_range(9))
         0, 1, 2, 3: add_bulk();
         4, 5: begin
            msg_q.push_back(rsf_pkg::CH_COLON);
            add_str($sformatf("%0d", $urandom_range(999)));
            add_crlf();
         end
         6, 7, 8: begin
            msg_q.push_back($urandom_range(1) ? rsf_pkg::CH_PLUS : rsf_pkg::CH_MINUS);
            add_text(4);
            add_crlf();
         end
         default: msg_q.push_back(8'($urandom_range(255)));
      endcase
   endtask

   task make_message();
      int n, cnt;
      msg_q.delete();
      case ($urandom_range(11))
         0, 1, 2: begin
            msg_q.push_back($urandom_range(2) == 0 ? rsf_pkg::CH_PLUS
                            : ($urandom_range(1) ? rsf_pkg::CH_MINUS : rsf_pkg::CH_COLON));
            add_text(6);
            if ($urandom_range(3) != 0) add_crlf();
         end
         3, 4: add_bulk();
         5, 6, 7, 8: begin
            cnt = $urandom_range(6) == 0 ? -1 - $urandom_range(2) : $urandom_range(4);
            msg_q.push_back(rsf_pkg::CH_ARRAY);
            add_count(cnt);
            for (int i = 0; i < cnt; i++) add_element();
         end
         9: msg_q.push_back(8'($urandom_range(255)));
         default: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom_range(255)));
         end
      endcase
      if ($urandom_range(5) > 0 && $urandom_range(99) < 15 && msg_q.size() > 1)
         msg_q = msg_q[0:$urandom_range(msg_q.size() - 1)];
      if ($urandom_range(5) == 0) add_text(3);
      if (msg_q.size() == 0) msg_q.push_back(rsf_pkg::CH_PLUS);
   endtask

   task send_message();
      for (int i = 0; i < msg_q.size(); i++) begin
         while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(posedge clock);
         end
         push <= 1;
         req_data_byte <= msg_q[i];
         req_end_of_message <= (i == msg_q.size() - 1);
         do @(posedge clock); while (full);
         sent++;
      end
      push <= 0;
   endtask

   task send_str(input string s);
      msg_q.delete();
      add_str(s);
      send_message();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_str("+OK\r\n");
      send_str("$-1\r\n");
      send_str("$0\r\n");
      send_str("*-1\r\n");
      send_str("?");
      send_str("*1\r\n?");
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 73; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 73; end
            default: begin send_idle = 11; recv_idle = 11; end
         endcase
         if (ph == 2) hold_req = 1;
         while (sent < 25 + (ph + 1) * 51) begin
            make_message();
            send_message();
         end
         if (ph == 5) wait (pending == 0);
      end
      recv_idle = 0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("resp_stream_flattener_unit_tb OK");
      else $display("resp_stream_flattener_unit_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/rsf_pkg.sv
rtl/core/rsf_front.sv
rtl/core/rsf_cmd_fifo.sv
rtl/core/rsf_back.sv
rtl/core/resp_stream_flattener_unit.sv
rtl/core/rsf_checker.sv
tb/sv/resp_stream_flattener_unit_chk.sv
tb/sv/resp_stream_flattener_unit_tb.sv
